// ===== hw/rtl/i2cms_pkg.sv =====
// Shared types, codes and constants of the I2C master transfer sequencer.
package i2cms_pkg;

	localparam int BUFFER_DEPTH = 32;
	localparam int BUF_AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int CFG_IW = 3;

	typedef enum logic [2:0] {
		FUNC_LOAD   = 3'd0,
		FUNC_WRITE  = 3'd1,
		FUNC_READ   = 3'd2,
		FUNC_STATUS = 3'd3,
		FUNC_PEEK   = 3'd4
	} func_t;

	typedef enum logic [3:0] {
		CMD_NONE    = 4'd0,
		CMD_START   = 4'd1,
		CMD_RESTART = 4'd2,
		CMD_SEND    = 4'd3,
		CMD_RX_ACK  = 4'd4,
		CMD_RX_NACK = 4'd5,
		CMD_STOP    = 4'd6,
		CMD_RELEASE = 4'd7,
		CMD_RECOVER = 4'd8
	} cmd_t;

	typedef enum logic [2:0] {
		RES_PENDING   = 3'd0,
		RES_SUCCESS   = 3'd1,
		RES_ADDR_FAIL = 3'd2,
		RES_DATA_FAIL = 3'd3,
		RES_NOT_SUPP  = 3'd4,
		RES_UNKNOWN   = 3'd5,
		RES_BUS_ERR   = 3'd6
	} res_t;

	typedef enum logic [CFG_IW-1:0] {
		REG_TARGET_ADDR = 3'd0,
		REG_LENGTH      = 3'd1,
		REG_RETRY_LIMIT = 3'd2,
		REG_HOLD_BUS    = 3'd3,
		REG_REP_START   = 3'd4
	} cfg_reg_t;

	// Bus status codes, low three bits dropped
	localparam logic [4:0] ST_BUS_ERR       = 5'h00;
	localparam logic [4:0] ST_START         = 5'h01;
	localparam logic [4:0] ST_RESTART       = 5'h02;
	localparam logic [4:0] ST_MT_SLA_ACK    = 5'h03;
	localparam logic [4:0] ST_MT_SLA_NACK   = 5'h04;
	localparam logic [4:0] ST_MT_DATA_ACK   = 5'h05;
	localparam logic [4:0] ST_MT_DATA_NACK  = 5'h06;
	localparam logic [4:0] ST_MR_SLA_ACK    = 5'h08;
	localparam logic [4:0] ST_MR_SLA_NACK   = 5'h09;
	localparam logic [4:0] ST_MR_DATA_ACK   = 5'h0A;
	localparam logic [4:0] ST_MR_DATA_NACK  = 5'h0B;
	localparam logic [4:0] ST_SLAVE_LO      = 5'h07;
	localparam logic [4:0] ST_SLAVE_HI      = 5'h19;
	localparam logic [4:0] ST_NO_INFO       = 5'h1F;

	typedef struct packed {
		logic [7:0] target_address_rw;
		logic [5:0] transfer_length;
		logic [7:0] retry_limit;
		logic       hold_bus;
		logic       use_repeated_start;
	} cfg_t;

	typedef struct packed {
		logic              we;
		logic [BUF_AW-1:0] waddr;
		logic [7:0]        wdata;
		logic              re;
		logic [BUF_AW-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] tx;
		logic       tx_from_mem;
		res_t       result;
		logic       done;
		logic       rdata_from_mem;
	} decision_t;

	function automatic logic [BUF_AW-1:0] buf_addr(input logic [4:0] pos);
		int tmp;
		tmp = int'(pos) % BUFFER_DEPTH;
		return BUF_AW'(tmp);
	endfunction

endpackage

// ===== hw/rtl/i2cms_if.sv =====
// Handshake channel interfaces: request, response and configuration.
interface i2cms_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] func;
	logic [4:0] index;
	logic [7:0] wdata;
	logic [7:0] status;
	logic [7:0] rx_byte;
	modport source (output valid, func, index, wdata, status, rx_byte, input ready);
	modport sink (input valid, func, index, wdata, status, rx_byte, output ready);
endinterface

interface i2cms_rsp_if;
	logic       valid;
	logic       ready;
	logic [3:0] bus_command;
	logic [7:0] tx_byte;
	logic [2:0] result;
	logic       done_res;
	logic [7:0] rdata;
	modport source (output valid, bus_command, tx_byte, result, done_res, rdata, input ready);
	modport sink (input valid, bus_command, tx_byte, result, done_res, rdata, output ready);
endinterface

interface i2cms_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] index;
	logic [7:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/i2cms_buffer.sv =====
// Transfer buffer: single write port, registered read port.
module i2cms_buffer (
	input  logic               clk,
	input  i2cms_pkg::mem_req_t req,
	output logic [7:0]         rd_data
);
	import i2cms_pkg::*;

	logic [7:0] mem [BUFFER_DEPTH];
	logic [7:0] rd_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rd_q <= mem[req.raddr];
		end
	end

	assign rd_data = rd_q;
endmodule

// ===== hw/rtl/i2cms_ctrl.sv =====
// Event decoder: picks the next bus command and updates the transfer state.
module i2cms_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [2:0]           func,
	input  logic [4:0]           index,
	input  logic [7:0]           wdata,
	input  logic [7:0]           status,
	input  logic [7:0]           rx_byte,
	input  i2cms_pkg::cfg_t      cfg,
	output i2cms_pkg::mem_req_t  mem_req,
	output i2cms_pkg::decision_t dec
);
	import i2cms_pkg::*;

	logic [4:0] byte_index_q, byte_index_d;
	logic [7:0] retry_count_q, retry_count_d;
	res_t       working_q, working_d;
	res_t       final_q, final_d;
	logic       read_q, read_d;
	logic [4:0] st;
	logic       known;
	logic [5:0] next_idx;
	logic [4:0] inc_idx;
	logic [5:0] inc_next;
	cmd_t       end_cmd;

	assign st       = status[7:3];
	assign next_idx = {1'b0, byte_index_q} + 6'd1;
	assign inc_idx  = byte_index_q + 5'd1;
	assign inc_next = {1'b0, inc_idx} + 6'd1;
	assign end_cmd  = cfg.hold_bus ? CMD_RELEASE : CMD_STOP;

	always_comb begin
		byte_index_d  = byte_index_q;
		retry_count_d = retry_count_q;
		working_d     = working_q;
		final_d       = final_q;
		read_d        = read_q;
		known         = 1'b1;
		mem_req       = '0;
		dec           = '0;
		dec.cmd       = CMD_NONE;
		dec.result    = RES_PENDING;
		case (func)
			FUNC_LOAD: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = buf_addr(index);
				mem_req.wdata = wdata;
			end
			FUNC_WRITE: begin
				read_d  = 1'b0;
				final_d = RES_PENDING;
				dec.cmd = cfg.use_repeated_start ? CMD_RESTART : CMD_START;
			end
			FUNC_READ: begin
				read_d  = 1'b1;
				final_d = RES_PENDING;
				dec.cmd = CMD_START;
			end
			FUNC_PEEK: begin
				mem_req.re         = 1'b1;
				mem_req.raddr      = buf_addr(index);
				dec.rdata_from_mem = 1'b1;
			end
			FUNC_STATUS: begin
				case (st)
					ST_BUS_ERR: begin
						working_d     = RES_BUS_ERR;
						retry_count_d = '0;
						byte_index_d  = '0;
						dec.cmd       = CMD_RECOVER;
					end
					ST_START, ST_RESTART: begin
						working_d = RES_PENDING;
						dec.cmd   = CMD_SEND;
						dec.tx    = {cfg.target_address_rw[7:1],
							cfg.target_address_rw[0] | read_q};
					end
					ST_MT_SLA_ACK: begin
						retry_count_d   = '0;
						byte_index_d    = '0;
						dec.cmd         = CMD_SEND;
						mem_req.re      = 1'b1;
						mem_req.raddr   = buf_addr(5'd0);
						dec.tx_from_mem = 1'b1;
					end
					ST_MT_SLA_NACK, ST_MR_SLA_NACK: begin
						working_d = RES_ADDR_FAIL;
						dec.cmd   = CMD_STOP;
					end
					ST_MT_DATA_ACK: begin
						if (next_idx < cfg.transfer_length) begin
							byte_index_d    = next_idx[4:0];
							dec.cmd         = CMD_SEND;
							mem_req.re      = 1'b1;
							mem_req.raddr   = buf_addr(next_idx[4:0]);
							dec.tx_from_mem = 1'b1;
						end else begin
							working_d = RES_SUCCESS;
							dec.cmd   = end_cmd;
						end
					end
					ST_MT_DATA_NACK: begin
						if (working_q == RES_ADDR_FAIL) begin
							dec.cmd = CMD_STOP;
						end else if (retry_count_q >= cfg.retry_limit) begin
							working_d = RES_DATA_FAIL;
							dec.cmd   = CMD_STOP;
						end else begin
							retry_count_d   = retry_count_q + 8'd1;
							dec.cmd         = CMD_SEND;
							mem_req.re      = 1'b1;
							mem_req.raddr   = buf_addr(byte_index_q);
							dec.tx_from_mem = 1'b1;
						end
					end
					ST_MR_SLA_ACK: begin
						retry_count_d = '0;
						byte_index_d  = '0;
						dec.cmd = (cfg.transfer_length <= 6'd1) ? CMD_RX_NACK : CMD_RX_ACK;
					end
					ST_MR_DATA_ACK: begin
						mem_req.we    = 1'b1;
						mem_req.waddr = buf_addr(byte_index_q);
						mem_req.wdata = rx_byte;
						byte_index_d  = inc_idx;
						dec.cmd = (inc_next >= cfg.transfer_length) ? CMD_RX_NACK : CMD_RX_ACK;
					end
					ST_MR_DATA_NACK: begin
						mem_req.we    = 1'b1;
						mem_req.waddr = buf_addr(byte_index_q);
						mem_req.wdata = rx_byte;
						working_d     = RES_SUCCESS;
						dec.cmd       = end_cmd;
					end
					ST_NO_INFO: begin
						working_d = RES_UNKNOWN;
						dec.cmd   = CMD_STOP;
					end
					default: begin
						if (st inside {[ST_SLAVE_LO:ST_SLAVE_HI]}) begin
							working_d = RES_NOT_SUPP;
							dec.cmd   = CMD_STOP;
						end else begin
							known = 1'b0;
						end
					end
				endcase
				if (known && working_d != RES_PENDING) begin
					byte_index_d  = '0;
					retry_count_d = '0;
					final_d       = working_d;
					dec.done      = 1'b1;
				end
			end
			default: begin
			end
		endcase
		mem_req.we = mem_req.we & accept;
		mem_req.re = mem_req.re & accept;
		dec.result = final_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q  <= '0;
			retry_count_q <= '0;
			working_q     <= RES_PENDING;
			final_q       <= RES_PENDING;
			read_q        <= 1'b0;
		end else if (accept) begin
			byte_index_q  <= byte_index_d;
			retry_count_q <= retry_count_d;
			working_q     <= working_d;
			final_q       <= final_d;
			read_q        <= read_d;
		end
	end
endmodule

// ===== hw/rtl/i2c_master_transfer_sequencer_top.sv =====
// I2C master transfer sequencer top level: config registers, buffer and response stage.
//
// Usage:
//   req  : one transaction per buffer load, transfer start, bus status event or
//          buffer read (func selects which).
//   rsp  : exactly one transaction per accepted request: next bus command, byte
//          to send, final result, done flag and read-back byte.
//   cfg  : register writes (index 0..4), always ready; write only while idle.
// Latency: the response is valid the cycle after the request is accepted.
// Throughput: one request per cycle while rsp.ready is high or no response is held.
// The decision is taken in the accept cycle and the buffer is read at the same edge,
// so its registered read data lines up with the response register.
// Reset: transfer state and config return to defaults, no response pending.
// Buffer contents are undefined until loaded; no clearing pass.
// Stall: the response register holds; req.ready drops while a held response
// is not taken and rises in the same cycle rsp.ready is seen.
module i2c_master_transfer_sequencer_top (
	input logic          clk,
	input logic          arst_n,
	i2cms_req_if.sink    req,
	i2cms_rsp_if.source  rsp,
	i2cms_cfg_if.sink    cfg
);
	import i2cms_pkg::*;

	cfg_t      cfg_q;
	mem_req_t  mem_req;
	decision_t dec;
	decision_t dec_s2;
	logic      valid_s2;
	logic      accept;
	logic [7:0] rd_data;

	assign req.ready = !valid_s2 || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_address_rw  <= 8'd0;
			cfg_q.transfer_length    <= 6'd1;
			cfg_q.retry_limit        <= 8'd3;
			cfg_q.hold_bus           <= 1'b0;
			cfg_q.use_repeated_start <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_TARGET_ADDR: cfg_q.target_address_rw  <= cfg.data;
				REG_LENGTH:      cfg_q.transfer_length    <= cfg.data[5:0];
				REG_RETRY_LIMIT: cfg_q.retry_limit        <= cfg.data;
				REG_HOLD_BUS:    cfg_q.hold_bus           <= cfg.data[0];
				REG_REP_START:   cfg_q.use_repeated_start <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

	i2cms_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.func    (req.func),
		.index   (req.index),
		.wdata   (req.wdata),
		.status  (req.status),
		.rx_byte (req.rx_byte),
		.cfg     (cfg_q),
		.mem_req (mem_req),
		.dec     (dec)
	);

	i2cms_buffer u_buffer (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (req.ready) begin
			valid_s2 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dec_s2 <= dec;
		end
	end

	assign rsp.valid       = valid_s2;
	assign rsp.bus_command = dec_s2.cmd;
	assign rsp.tx_byte     = dec_s2.tx_from_mem ? rd_data : dec_s2.tx;
	assign rsp.result      = dec_s2.result;
	assign rsp.done_res    = dec_s2.done;
	assign rsp.rdata       = dec_s2.rdata_from_mem ? rd_data : 8'd0;

	a_done_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && dec_s2.done) |-> (dec_s2.result != RES_PENDING))
		else $error("done without a final result");

	a_accept_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s2)
		else $error("accepted transaction produced no response");

	a_recover_is_bus_err: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && dec_s2.cmd == CMD_RECOVER) |->
		(dec_s2.done && dec_s2.result == RES_BUS_ERR))
		else $error("recover command without bus error result");

	a_one_mem_source: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_req.we || mem_req.re) |-> accept)
		else $error("buffer access outside an accepted transaction");
endmodule

// ===== tb/sv/i2cms_checker.sv =====
`timescale 1ns / 1ps
// Transaction checker: predicts each response of the transfer sequencer and compares it.
module i2cms_checker (
	input  logic clk,
	input  logic arst_n,
	i2cms_req_if req,
	i2cms_rsp_if rsp,
	i2cms_cfg_if cfg,
	output int   fail_count,
	output int   pending
);
	import i2cms_pkg::*;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] tx;
		res_t       result;
		logic       done;
		logic [7:0] rdata;
	} reply_t;

	logic [7:0] buf_q [BUFFER_DEPTH];
	logic [4:0] byte_idx;
	logic [7:0] retries;
	res_t       work_res;
	res_t       final_res;
	logic       rd_xfer;
	cfg_t       regs;
	reply_t     reply_q [$];

	function automatic cmd_t end_cmd();
		return regs.hold_bus ? CMD_RELEASE : CMD_STOP;
	endfunction

	function automatic reply_t next_decision(input logic [2:0] func, input logic [4:0] idx,
			input logic [7:0] wdata, input logic [7:0] status, input logic [7:0] rx);
		reply_t r;
		logic [4:0] code;
		logic [5:0] nxt;
		logic known;
		r = '{cmd: CMD_NONE, tx: 8'h00, result: RES_PENDING, done: 1'b0, rdata: 8'h00};
		code = status[7:3];
		known = 1'b1;
		case (func)
		FUNC_LOAD: begin
			buf_q[int'(idx) % BUFFER_DEPTH] = wdata;
		end
		FUNC_WRITE: begin
			rd_xfer = 1'b0;
			final_res = RES_PENDING;
			r.cmd = regs.use_repeated_start ? CMD_RESTART : CMD_START;
		end
		FUNC_READ: begin
			rd_xfer = 1'b1;
			final_res = RES_PENDING;
			r.cmd = CMD_START;
		end
		FUNC_PEEK: begin
			r.rdata = buf_q[int'(idx) % BUFFER_DEPTH];
		end
		FUNC_STATUS: begin
			case (code)
			ST_BUS_ERR: begin
				work_res = RES_BUS_ERR;
				retries = '0;
				byte_idx = '0;
				r.cmd = CMD_RECOVER;
			end
			ST_START, ST_RESTART: begin
				work_res = RES_PENDING;
				r.cmd = CMD_SEND;
				r.tx = regs.target_address_rw | {7'd0, rd_xfer};
			end
			ST_MT_SLA_ACK: begin
				retries = '0;
				byte_idx = '0;
				r.cmd = CMD_SEND;
				r.tx = buf_q[0];
			end
			ST_MT_SLA_NACK, ST_MR_SLA_NACK: begin
				work_res = RES_ADDR_FAIL;
				r.cmd = CMD_STOP;
			end
			ST_MT_DATA_ACK: begin
				nxt = {1'b0, byte_idx} + 6'd1;
				if (nxt < regs.transfer_length) begin
					byte_idx = nxt[4:0];
					r.cmd = CMD_SEND;
					r.tx = buf_q[int'(byte_idx) % BUFFER_DEPTH];
				end else begin
					work_res = RES_SUCCESS;
					r.cmd = end_cmd();
				end
			end
			ST_MT_DATA_NACK: begin
				if (work_res == RES_ADDR_FAIL) begin
					r.cmd = CMD_STOP;
				end else if (retries >= regs.retry_limit) begin
					work_res = RES_DATA_FAIL;
					r.cmd = CMD_STOP;
				end else begin
					retries = retries + 8'd1;
					r.cmd = CMD_SEND;
					r.tx = buf_q[int'(byte_idx) % BUFFER_DEPTH];
				end
			end
			ST_MR_SLA_ACK: begin
				retries = '0;
				byte_idx = '0;
				r.cmd = (regs.transfer_length <= 6'd1) ? CMD_RX_NACK : CMD_RX_ACK;
			end
			ST_MR_DATA_ACK: begin
				buf_q[int'(byte_idx) % BUFFER_DEPTH] = rx;
				byte_idx = byte_idx + 5'd1;
				nxt = {1'b0, byte_idx} + 6'd1;
				r.cmd = (nxt >= regs.transfer_length) ? CMD_RX_NACK : CMD_RX_ACK;
			end
			ST_MR_DATA_NACK: begin
				buf_q[int'(byte_idx) % BUFFER_DEPTH] = rx;
				work_res = RES_SUCCESS;
				r.cmd = end_cmd();
			end
			ST_NO_INFO: begin
				work_res = RES_UNKNOWN;
				r.cmd = CMD_STOP;
			end
			default: begin
				// arbitration lost and slave-mode codes; any other code is left unrecognised
				if (code >= ST_SLAVE_LO && code <= ST_SLAVE_HI) begin
					work_res = RES_NOT_SUPP;
					r.cmd = CMD_STOP;
				end else begin
					known = 1'b0;
				end
			end
			endcase
			if (known && work_res != RES_PENDING) begin
				byte_idx = '0;
				retries = '0;
				final_res = work_res;
				r.done = 1'b1;
			end
		end
		default: ;
		endcase
		r.result = final_res;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [7:0] exp_v,
			input logic [7:0] act_v);
		if (act_v !== exp_v) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		reply_t exp_r;
		if (!arst_n) begin
			byte_idx = '0;
			retries = '0;
			work_res = RES_PENDING;
			final_res = RES_PENDING;
			rd_xfer = 1'b0;
			regs = '{target_address_rw: 8'd0, transfer_length: 6'd1, retry_limit: 8'd3,
				hold_bus: 1'b0, use_repeated_start: 1'b0};
			reply_q.delete();
			fail_count = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
				REG_TARGET_ADDR: regs.target_address_rw = cfg.data;
				REG_LENGTH:      regs.transfer_length = cfg.data[5:0];
				REG_RETRY_LIMIT: regs.retry_limit = cfg.data;
				REG_HOLD_BUS:    regs.hold_bus = cfg.data[0];
				REG_REP_START:   regs.use_repeated_start = cfg.data[0];
				default: ;
				endcase
			end
			// a response is registered after its request is accepted, so pop before push
			if (rsp.valid && rsp.ready) begin
				if (reply_q.size() == 0) begin
					fail_count++;
					$display("%0t: response transaction with none expected, command %0h",
						$time, rsp.bus_command);
				end else begin
					exp_r = reply_q.pop_front();
					check_field("bus_command", {4'd0, exp_r.cmd}, {4'd0, rsp.bus_command});
					check_field("tx_byte", exp_r.tx, rsp.tx_byte);
					check_field("result", {5'd0, exp_r.result}, {5'd0, rsp.result});
					check_field("done_res", {7'd0, exp_r.done}, {7'd0, rsp.done_res});
					check_field("rdata", exp_r.rdata, rsp.rdata);
				end
			end
			if (req.valid && req.ready)
				reply_q.push_back(next_decision(req.func, req.index, req.wdata, req.status,
					req.rx_byte));
		end
		pending = reply_q.size();
	end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top: clock, reset, stimulus for the transfer sequencer and the verdict.
module tb_top;
	import i2cms_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int ITEM_TARGET = 1500;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   n_items;
	int   idle_cycles;
	bit   quiet_tx;
	bit   quiet_rx;
	cfg_t cur_cfg;

	i2cms_req_if req_bus ();
	i2cms_rsp_if rsp_bus ();
	i2cms_cfg_if cfg_bus ();

	i2c_master_transfer_sequencer_top i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_bus),
		.rsp   (rsp_bus),
		.cfg   (cfg_bus)
	);

	i2cms_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_bus),
		.rsp       (rsp_bus),
		.cfg       (cfg_bus),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
				|| (cfg_bus.valid && cfg_bus.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic int idle_len();
		return ($urandom_range(0, 99) < 75) ? $urandom_range(1, 3) : $urandom_range(8, 30);
	endfunction

	initial begin : rsp_sink
		int hold;
		bit level;
		hold = 0;
		level = 1'b1;
		rsp_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold == 0) begin
				level = quiet_rx || ($urandom_range(0, 3) != 0);
				hold = level ? $urandom_range(1, 12) : idle_len();
			end
			hold--;
			rsp_bus.ready = level;
		end
	end

	task automatic send(input logic [2:0] f, input logic [4:0] idx, input logic [7:0] wd,
			input logic [7:0] st, input logic [7:0] rx);
		int gap;
		gap = (quiet_tx || $urandom_range(0, 1) == 0) ? 0 : idle_len();
		if (gap > 0) begin
			@(negedge clk);
			req_bus.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_bus.valid = 1'b1;
		req_bus.func = f;
		req_bus.index = idx;
		req_bus.wdata = wd;
		req_bus.status = st;
		req_bus.rx_byte = rx;
		@(posedge clk);
		while (!req_bus.ready) @(posedge clk);
		// ignored transactions do not count toward the run length
		if (f <= FUNC_PEEK && !(f == FUNC_STATUS && st[7:3] > ST_SLAVE_HI
				&& st[7:3] < ST_NO_INFO))
			n_items++;
	endtask

	task automatic bus_event(input logic [4:0] code);
		send(FUNC_STATUS, 5'($urandom), 8'($urandom), {code, 3'($urandom)}, 8'($urandom));
	endtask

	function automatic logic [4:0] abort_code();
		case ($urandom_range(0, 4))
		0: return ST_BUS_ERR;
		1: return ST_NO_INFO;
		2: return ST_SLAVE_LO;
		3: return 5'($urandom_range(ST_SLAVE_LO, ST_SLAVE_HI));
		default: return 5'($urandom_range(ST_SLAVE_HI + 1, ST_NO_INFO - 1));
		endcase
	endfunction

	task automatic drain();
		@(negedge clk);
		req_bus.valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic put_reg(input cfg_reg_t r, input logic [7:0] d);
		@(negedge clk);
		cfg_bus.valid = 1'b1;
		cfg_bus.index = r;
		cfg_bus.data = d;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
	endtask

	task automatic write_cfg(input cfg_t c);
		put_reg(REG_TARGET_ADDR, c.target_address_rw);
		put_reg(REG_LENGTH, {2'b00, c.transfer_length});
		put_reg(REG_RETRY_LIMIT, c.retry_limit);
		put_reg(REG_HOLD_BUS, {7'd0, c.hold_bus});
		put_reg(REG_REP_START, {7'd0, c.use_repeated_start});
		@(negedge clk);
		cfg_bus.valid = 1'b0;
		cur_cfg = c;
	endtask

	function automatic cfg_t random_cfg();
		cfg_t c;
		c.target_address_rw = 8'($urandom);
		case ($urandom_range(0, 9))
		0: c.transfer_length = 6'd0;
		1: c.transfer_length = 6'd32;
		2: c.transfer_length = 6'($urandom);
		default: c.transfer_length = 6'($urandom_range(1, 8));
		endcase
		c.retry_limit = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
		c.hold_bus = 1'($urandom);
		c.use_repeated_start = 1'($urandom);
		return c;
	endfunction

	task automatic run_write();
		int nb;
		int tries;
		tries = 0;
		nb = (cur_cfg.transfer_length == 0) ? 1 : int'(cur_cfg.transfer_length);
		send(FUNC_WRITE, 5'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		bus_event((cur_cfg.use_repeated_start ^ ($urandom_range(0, 7) == 0))
			? ST_RESTART : ST_START);
		if ($urandom_range(0, 9) == 0) begin
			bus_event(ST_MT_SLA_NACK);
			if ($urandom_range(0, 1) == 0)
				bus_event(ST_MT_DATA_NACK);
			return;
		end
		bus_event(ST_MT_SLA_ACK);
		for (int i = 0; i < nb; i++) begin
			while ($urandom_range(0, 5) == 0) begin
				bus_event(ST_MT_DATA_NACK);
				if (tries == int'(cur_cfg.retry_limit))
					return;
				tries++;
			end
			if ($urandom_range(0, 29) == 0) begin
				bus_event(abort_code());
				return;
			end
			bus_event(ST_MT_DATA_ACK);
		end
		if ($urandom_range(0, 7) == 0)
			bus_event(5'($urandom));
	endtask

	task automatic run_read();
		int nb;
		nb = (cur_cfg.transfer_length == 0) ? 1 : int'(cur_cfg.transfer_length);
		send(FUNC_READ, 5'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		bus_event(($urandom_range(0, 7) == 0) ? ST_RESTART : ST_START);
		if ($urandom_range(0, 9) == 0) begin
			bus_event(ST_MR_SLA_NACK);
			return;
		end
		bus_event(ST_MR_SLA_ACK);
		for (int i = 0; i < nb - 1; i++) begin
			if ($urandom_range(0, 29) == 0) begin
				bus_event(abort_code());
				return;
			end
			bus_event(ST_MR_DATA_ACK);
		end
		bus_event(ST_MR_DATA_NACK);
		if ($urandom_range(0, 3) == 0)
			send(FUNC_PEEK, 5'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic run_noise();
		logic [2:0] f;
		repeat ($urandom_range(1, 5)) begin
			f = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(FUNC_PEEK + 1, 7))
				: 3'($urandom_range(FUNC_LOAD, FUNC_PEEK));
			send(f, 5'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		end
	endtask

	task automatic run_phase(input cfg_t c, input int budget);
		int stop_at;
		drain();
		write_cfg(c);
		quiet_tx = ($urandom_range(0, 4) == 0);
		quiet_rx = ($urandom_range(0, 4) == 0);
		stop_at = n_items + budget;
		while (n_items < stop_at) begin
			case ($urandom_range(0, 9))
			0, 1, 2, 3: run_write();
			4, 5, 6, 7: run_read();
			default: run_noise();
			endcase
		end
	endtask

	initial begin
		req_bus.valid = 1'b0;
		req_bus.func = FUNC_LOAD;
		req_bus.index = '0;
		req_bus.wdata = '0;
		req_bus.status = '0;
		req_bus.rx_byte = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = REG_TARGET_ADDR;
		cfg_bus.data = '0;
		quiet_tx = 1'b0;
		quiet_rx = 1'b0;
		n_items = 0;
		cur_cfg = '{target_address_rw: 8'd0, transfer_length: 6'd1, retry_limit: 8'd3,
			hold_bus: 1'b0, use_repeated_start: 1'b0};
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// every buffer entry written before anything can read it
		for (int i = 0; i < BUFFER_DEPTH; i++)
			send(FUNC_LOAD, 5'(i), 8'($urandom), 8'($urandom), 8'($urandom));

		// directed: default settings
		send(FUNC_PEEK, 5'd0, 8'h00, 8'h00, 8'h00);
		send(FUNC_PEEK, 5'd31, 8'hFF, 8'hFF, 8'hFF);
		for (int f = FUNC_PEEK + 1; f < 8; f++)
			send(3'(f), 5'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		send(FUNC_WRITE, 5'd0, 8'h00, 8'h00, 8'h00);
		bus_event(ST_START);
		bus_event(ST_MT_SLA_ACK);
		bus_event(ST_MT_DATA_NACK);
		bus_event(ST_MT_DATA_ACK);
		send(FUNC_READ, 5'd31, 8'hFF, 8'hFF, 8'hFF);
		bus_event(ST_RESTART);
		bus_event(ST_MR_SLA_ACK);
		send(FUNC_STATUS, 5'd0, 8'h00, {ST_MR_DATA_NACK, 3'b111}, 8'hFF);
		send(FUNC_STATUS, 5'd0, 8'h00, 8'h00, 8'h00);
		send(FUNC_STATUS, 5'd31, 8'hFF, 8'hFF, 8'hFF);
		bus_event(ST_SLAVE_LO);
		send(FUNC_STATUS, 5'd0, 8'h00, {ST_SLAVE_HI, 3'b000}, 8'h00);
		bus_event(5'(ST_SLAVE_HI + 1));
		bus_event(ST_MT_SLA_NACK);
		bus_event(ST_MT_DATA_NACK);
		bus_event(ST_MR_SLA_NACK);
		send(FUNC_LOAD, 5'd31, 8'hFF, 8'h00, 8'h00);
		send(FUNC_LOAD, 5'd0, 8'h00, 8'hFF, 8'hFF);

		// extreme settings first, then random ones
		run_phase('{target_address_rw: 8'h00, transfer_length: 6'd0, retry_limit: 8'd0,
			hold_bus: 1'b1, use_repeated_start: 1'b1}, 80);
		run_phase('{target_address_rw: 8'hFF, transfer_length: 6'd63, retry_limit: 8'd255,
			hold_bus: 1'b0, use_repeated_start: 1'b0}, 150);
		run_phase('{target_address_rw: 8'hA4, transfer_length: 6'd32, retry_limit: 8'd1,
			hold_bus: 1'b1, use_repeated_start: 1'b0}, 100);
		run_phase('{target_address_rw: 8'h5B, transfer_length: 6'd1, retry_limit: 8'd2,
			hold_bus: 1'b0, use_repeated_start: 1'b1}, 80);
		while (n_items < ITEM_TARGET)
			run_phase(random_cfg(), $urandom_range(60, 120));

		drain();
		repeat (4) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
